// File: rtl/core/pswt_pkg.sv
package pswt_pkg;

    // Default sizes
    localparam int SOURCES_DEF = 16;
    localparam int PINGS_DEF   = 8;

    // Operation codes carried on s_tuser
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_CLEANUP = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // Configuration register indexes
    localparam int         CFG_ADDR_W    = 1;
    localparam logic       CFG_TIMEOUT   = 1'b0;
    localparam logic       CFG_MIN_PINGS = 1'b1;
    localparam int         CFG_DATA_W    = 16;

    localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
    localparam logic [3:0]  MIN_PINGS_RST = 4'd3;

    // Stream payload widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;

    // Memory strobes from the sequencer to the store
    typedef struct packed {
        logic ping_re;
        logic ping_we;
        logic meta_re;
        logic meta_we;
        logic meta_clr;
    } pswt_mem_ctl_t;

endpackage

// File: rtl/core/pswt_store.sv
module pswt_store #(
    parameter int SOURCES = pswt_pkg::SOURCES_DEF,
    parameter int PINGS   = pswt_pkg::PINGS_DEF,
    localparam int SW  = (SOURCES > 1) ? $clog2(SOURCES) : 1,
    localparam int PSW = (PINGS > 1) ? $clog2(PINGS) : 1,
    localparam int CW  = $clog2(PINGS + 1),
    localparam int AW  = (SOURCES * PINGS > 1) ? $clog2(SOURCES * PINGS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pswt_pkg::pswt_mem_ctl_t mem_ctl,
    input  logic [AW-1:0]           ping_raddr,
    input  logic [AW-1:0]           ping_waddr,
    input  logic [31:0]             ping_wdata,
    output logic [31:0]             ping_rdata,
    input  logic [SW-1:0]           meta_addr,
    input  logic [CW-1:0]           meta_wfill,
    input  logic [PSW-1:0]          meta_wold,
    output logic [CW-1:0]           meta_rfill,
    output logic [PSW-1:0]          meta_rold
);
    import pswt_pkg::*;

    localparam int DEPTH = SOURCES * PINGS;
    localparam int MW    = CW + PSW;

    logic [31:0]        ping_mem [DEPTH];
    logic [31:0]        ping_rd_reg;

    logic [MW-1:0]      meta_mem [SOURCES];
    logic [MW-1:0]      meta_rd_reg;
    logic               meta_rdv_reg;
    logic               meta_rdv_next;
    logic [SOURCES-1:0] meta_vld_reg;
    logic [SOURCES-1:0] meta_vld_next;

    // Timestamp ring storage
    always_ff @(posedge aclk) begin
        if (mem_ctl.ping_we) begin
            ping_mem[ping_waddr] <= ping_wdata;
        end
        if (mem_ctl.ping_re) begin
            ping_rd_reg <= ping_mem[ping_raddr];
        end
    end

    assign ping_rdata = ping_rd_reg;

    // Per-source fill count and oldest slot
    always_ff @(posedge aclk) begin
        if (mem_ctl.meta_we) begin
            meta_mem[meta_addr] <= {meta_wfill, meta_wold};
        end
        if (mem_ctl.meta_re) begin
            meta_rd_reg <= meta_mem[meta_addr];
        end
    end

    // An entry not written since reset or clear reads as empty
    always_comb begin
        meta_vld_next = meta_vld_reg;
        meta_rdv_next = meta_rdv_reg;
        if (mem_ctl.meta_re) begin
            meta_rdv_next = meta_vld_reg[meta_addr];
        end
        if (mem_ctl.meta_clr) begin
            meta_vld_next = '0;
        end else if (mem_ctl.meta_we) begin
            meta_vld_next[meta_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta_vld_reg <= '0;
            meta_rdv_reg <= 1'b0;
        end else begin
            meta_vld_reg <= meta_vld_next;
            meta_rdv_reg <= meta_rdv_next;
        end
    end

    assign meta_rfill = meta_rdv_reg ? meta_rd_reg[MW-1:PSW] : '0;
    assign meta_rold  = meta_rdv_reg ? meta_rd_reg[PSW-1:0]  : '0;

endmodule

// File: rtl/core/pswt_ctrl.sv
module pswt_ctrl #(
    parameter int SOURCES = pswt_pkg::SOURCES_DEF,
    parameter int PINGS   = pswt_pkg::PINGS_DEF,
    localparam int SW  = (SOURCES > 1) ? $clog2(SOURCES) : 1,
    localparam int PSW = (PINGS > 1) ? $clog2(PINGS) : 1,
    localparam int CW  = $clog2(PINGS + 1),
    localparam int AW  = (SOURCES * PINGS > 1) ? $clog2(SOURCES * PINGS) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              in_op,
    input  logic [3:0]              in_source,
    input  logic [31:0]             in_now,
    input  logic [15:0]             timeout_ms,
    input  logic [3:0]              min_pings,
    output pswt_pkg::pswt_mem_ctl_t mem_ctl,
    output logic [AW-1:0]           ping_raddr,
    output logic [AW-1:0]           ping_waddr,
    output logic [31:0]             ping_wdata,
    input  logic [31:0]             ping_rdata,
    output logic [SW-1:0]           meta_addr,
    output logic [CW-1:0]           meta_wfill,
    output logic [PSW-1:0]          meta_wold,
    input  logic [CW-1:0]           meta_rfill,
    input  logic [PSW-1:0]          meta_rold,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3:0]              stored_count,
    output logic [3:0]              valid_count,
    output logic                    enough,
    output logic [15:0]             active_mask,
    output logic [31:0]             last_time,
    output logic [31:0]             since_last
);
    import pswt_pkg::*;

    localparam int SUMW = PSW + 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ADD_RD  = 3'd1;
    localparam logic [2:0] ST_ADD_WR  = 3'd2;
    localparam logic [2:0] ST_META_RD = 3'd3;
    localparam logic [2:0] ST_PING    = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    function automatic logic [PSW-1:0] wrap_slot(input logic [SUMW-1:0] x);
        logic [SUMW-1:0] lim;
        lim = SUMW'(PINGS);
        wrap_slot = (x >= lim) ? PSW'(x - lim) : PSW'(x);
    endfunction

    logic [2:0]     state_reg,      state_next;
    logic [1:0]     op_reg,         op_next;
    logic [3:0]     src_reg,        src_next;
    logic           inr_reg,        inr_next;
    logic [31:0]    now_reg,        now_next;
    logic [AW-1:0]  src_base_reg,   src_base_next;
    logic [SW-1:0]  s_reg,          s_next;
    logic [AW-1:0]  base_reg,       base_next;
    logic [CW-1:0]  i_reg,          i_next;
    logic           pend_reg,       pend_next;
    logic [CW-1:0]  cnt_reg,        cnt_next;
    logic [CW-1:0]  kept_reg,       kept_next;
    logic [31:0]    cur_last_reg,   cur_last_next;
    logic [15:0]    mask_reg,       mask_next;
    logic [CW-1:0]  res_stored_reg, res_stored_next;
    logic [CW-1:0]  res_valid_reg,  res_valid_next;
    logic [31:0]    res_last_reg,   res_last_next;
    logic           res_has_reg,    res_has_next;
    logic           out_valid_reg,  out_valid_next;
    logic [3:0]     out_stored_reg, out_stored_next;
    logic [3:0]     out_vcnt_reg,   out_vcnt_next;
    logic           out_enough_reg, out_enough_next;
    logic [15:0]    out_mask_reg,   out_mask_next;
    logic [31:0]    out_last_reg,   out_last_next;
    logic [31:0]    out_since_reg,  out_since_next;

    logic           in_inr;
    logic [PSW-1:0] ring_rd;
    logic [PSW-1:0] ring_wr;
    logic [31:0]    age;
    logic           ping_ok;
    logic           add_full;
    logic [PSW-1:0] add_slot;
    logic [PSW-1:0] old_inc;
    logic           src_done;
    logic           is_clean;
    logic [CW-1:0]  stored_s;
    logic           src_hit;

    assign in_inr   = 32'(in_source) < SOURCES;
    assign ring_rd  = wrap_slot(SUMW'(meta_rold) + SUMW'(i_reg));
    assign ring_wr  = wrap_slot(SUMW'(meta_rold) + SUMW'(kept_reg));
    assign age      = now_reg - ping_rdata;
    assign ping_ok  = age <= 32'(timeout_ms);
    assign add_full = meta_rfill == CW'(PINGS);
    assign add_slot = add_full ? meta_rold : wrap_slot(SUMW'(meta_rold) + SUMW'(meta_rfill));
    assign old_inc  = wrap_slot(SUMW'(meta_rold) + SUMW'(1));
    assign src_done = !pend_reg && (i_reg == meta_rfill);
    assign is_clean = op_reg == OP_CLEANUP;
    assign stored_s = is_clean ? kept_reg : meta_rfill;
    assign src_hit  = inr_reg && (32'(s_reg) == 32'(src_reg));

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        src_next        = src_reg;
        inr_next        = inr_reg;
        now_next        = now_reg;
        src_base_next   = src_base_reg;
        s_next          = s_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        kept_next       = kept_reg;
        cur_last_next   = cur_last_reg;
        mask_next       = mask_reg;
        res_stored_next = res_stored_reg;
        res_valid_next  = res_valid_reg;
        res_last_next   = res_last_reg;
        res_has_next    = res_has_reg;
        out_valid_next  = out_ready ? 1'b0 : out_valid_reg;
        out_stored_next = out_stored_reg;
        out_vcnt_next   = out_vcnt_reg;
        out_enough_next = out_enough_reg;
        out_mask_next   = out_mask_reg;
        out_last_next   = out_last_reg;
        out_since_next  = out_since_reg;

        mem_ctl    = '0;
        ping_raddr = base_reg + AW'(ring_rd);
        ping_waddr = base_reg + AW'(ring_wr);
        ping_wdata = ping_rdata;
        meta_addr  = s_reg;
        meta_wfill = kept_reg;
        meta_wold  = meta_rold;
        in_ready   = state_reg == ST_IDLE;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next         = in_op;
                    src_next        = in_source;
                    inr_next        = in_inr;
                    now_next        = in_now;
                    src_base_next   = AW'(32'(in_source) * PINGS);
                    s_next          = '0;
                    base_next       = '0;
                    mask_next       = '0;
                    res_stored_next = '0;
                    res_valid_next  = '0;
                    res_last_next   = '0;
                    res_has_next    = 1'b0;
                    unique case (in_op)
                        OP_ADD: begin
                            state_next = in_inr ? ST_ADD_RD : ST_META_RD;
                        end
                        OP_QUERY, OP_CLEANUP: begin
                            state_next = ST_META_RD;
                        end
                        OP_CLEAR: begin
                            mem_ctl.meta_clr = 1'b1;
                            state_next       = ST_META_RD;
                        end
                    endcase
                end
            end
            ST_ADD_RD: begin
                mem_ctl.meta_re = 1'b1;
                meta_addr       = SW'(src_reg);
                state_next      = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                // Append the ping; a full ring overwrites the oldest entry and advances past it
                mem_ctl.ping_we = 1'b1;
                ping_waddr      = src_base_reg + AW'(add_slot);
                ping_wdata      = now_reg;
                mem_ctl.meta_we = 1'b1;
                meta_addr       = SW'(src_reg);
                meta_wfill      = add_full ? meta_rfill : meta_rfill + CW'(1);
                meta_wold       = add_full ? old_inc : meta_rold;
                state_next      = ST_META_RD;
            end
            ST_META_RD: begin
                mem_ctl.meta_re = 1'b1;
                i_next          = '0;
                pend_next       = 1'b0;
                cnt_next        = '0;
                kept_next       = '0;
                state_next      = ST_PING;
            end
            ST_PING: begin
                // Process the timestamp read last cycle; survivors of a cleanup are
                // packed in ring order from the oldest slot on
                if (pend_reg) begin
                    cnt_next = cnt_reg + CW'(ping_ok);
                    if (is_clean) begin
                        if (ping_ok) begin
                            mem_ctl.ping_we = 1'b1;
                            kept_next       = kept_reg + CW'(1);
                            cur_last_next   = ping_rdata;
                        end
                    end else if (i_reg == meta_rfill) begin
                        cur_last_next = ping_rdata;
                    end
                end
                if (i_reg < meta_rfill) begin
                    mem_ctl.ping_re = 1'b1;
                    i_next          = i_reg + CW'(1);
                    pend_next       = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (src_done) begin
                    if (is_clean) begin
                        mem_ctl.meta_we = 1'b1;
                    end
                    mask_next = mask_reg | (16'(cnt_reg != '0) << s_reg);
                    if (src_hit) begin
                        res_stored_next = stored_s;
                        res_valid_next  = cnt_reg;
                        res_last_next   = cur_last_reg;
                        res_has_next    = stored_s != '0;
                    end
                    if (32'(s_reg) == 32'(SOURCES - 1)) begin
                        state_next = ST_DONE;
                    end else begin
                        s_next     = s_reg + SW'(1);
                        base_next  = base_reg + AW'(PINGS);
                        state_next = ST_META_RD;
                    end
                end
            end
            ST_DONE: begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    out_valid_next  = 1'b1;
                    out_stored_next = 4'(res_stored_reg);
                    out_vcnt_next   = 4'(res_valid_reg);
                    out_enough_next = 32'(res_valid_reg) >= 32'(min_pings);
                    out_mask_next   = mask_reg;
                    out_last_next   = res_has_reg ? res_last_reg : '0;
                    out_since_next  = res_has_reg ? now_reg - res_last_reg : '1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        src_reg        <= src_next;
        inr_reg        <= inr_next;
        now_reg        <= now_next;
        src_base_reg   <= src_base_next;
        s_reg          <= s_next;
        base_reg       <= base_next;
        i_reg          <= i_next;
        pend_reg       <= pend_next;
        cnt_reg        <= cnt_next;
        kept_reg       <= kept_next;
        cur_last_reg   <= cur_last_next;
        mask_reg       <= mask_next;
        res_stored_reg <= res_stored_next;
        res_valid_reg  <= res_valid_next;
        res_last_reg   <= res_last_next;
        res_has_reg    <= res_has_next;
        out_stored_reg <= out_stored_next;
        out_vcnt_reg   <= out_vcnt_next;
        out_enough_reg <= out_enough_next;
        out_mask_reg   <= out_mask_next;
        out_last_reg   <= out_last_next;
        out_since_reg  <= out_since_next;
    end

    assign out_valid    = out_valid_reg;
    assign stored_count = out_stored_reg;
    assign valid_count  = out_vcnt_reg;
    assign enough       = out_enough_reg;
    assign active_mask  = out_mask_reg;
    assign last_time    = out_last_reg;
    assign since_last   = out_since_reg;

endmodule

// File: rtl/core/per_source_ping_window_tracker_top.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser: op; s_tdata: source, now_ms
// m_        out        m_tvalid/m_tready  m_tdata: counts, enough, mask, last, since
// cfg_      in         cfg_we             cfg_addr: register, cfg_wdata: value
//
// One item at a time: each item walks every source, reading its fill count and
// then its held pings in turn; an add to a source in range first writes the ring.
// The pace is set by the timestamp memory, read one entry per cycle.
// Reset empties every source at once through per-source valid bits.
// A new item is taken while a result waits in the output register;
// m_tready low stalls the block only when the next result is ready.
module per_source_ping_window_tracker_top #(
    parameter int SOURCES = pswt_pkg::SOURCES_DEF,
    parameter int PINGS   = pswt_pkg::PINGS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pswt_pkg::S_TDATA_W-1:0]  s_tdata,   // source[3:0], now_ms[35:4]
    input  logic [pswt_pkg::S_TUSER_W-1:0]  s_tuser,   // op[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // stored_count[3:0], valid_count[7:4], enough[8], active_mask[24:9],
    // last_time[56:25], since_last[88:57]
    output logic [pswt_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [pswt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pswt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pswt_pkg::*;

    localparam int SW  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int PSW = (PINGS > 1) ? $clog2(PINGS) : 1;
    localparam int CW  = $clog2(PINGS + 1);
    localparam int AW  = (SOURCES * PINGS > 1) ? $clog2(SOURCES * PINGS) : 1;

    logic [15:0]    timeout_reg,   timeout_next;
    logic [3:0]     min_pings_reg, min_pings_next;

    pswt_mem_ctl_t  mem_ctl;
    logic [AW-1:0]  ping_raddr;
    logic [AW-1:0]  ping_waddr;
    logic [31:0]    ping_wdata;
    logic [31:0]    ping_rdata;
    logic [SW-1:0]  meta_addr;
    logic [CW-1:0]  meta_wfill;
    logic [PSW-1:0] meta_wold;
    logic [CW-1:0]  meta_rfill;
    logic [PSW-1:0] meta_rold;

    logic [3:0]     stored_count;
    logic [3:0]     valid_count;
    logic           enough;
    logic [15:0]    active_mask;
    logic [31:0]    last_time;
    logic [31:0]    since_last;

    always_comb begin
        timeout_next   = timeout_reg;
        min_pings_next = min_pings_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TIMEOUT:   timeout_next   = cfg_wdata;
                CFG_MIN_PINGS: min_pings_next = cfg_wdata[3:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RST;
            min_pings_reg <= MIN_PINGS_RST;
        end else begin
            timeout_reg   <= timeout_next;
            min_pings_reg <= min_pings_next;
        end
    end

    pswt_store #(
        .SOURCES (SOURCES),
        .PINGS   (PINGS)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mem_ctl    (mem_ctl),
        .ping_raddr (ping_raddr),
        .ping_waddr (ping_waddr),
        .ping_wdata (ping_wdata),
        .ping_rdata (ping_rdata),
        .meta_addr  (meta_addr),
        .meta_wfill (meta_wfill),
        .meta_wold  (meta_wold),
        .meta_rfill (meta_rfill),
        .meta_rold  (meta_rold)
    );

    pswt_ctrl #(
        .SOURCES (SOURCES),
        .PINGS   (PINGS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser[1:0]),
        .in_source    (s_tdata[3:0]),
        .in_now       (s_tdata[35:4]),
        .timeout_ms   (timeout_reg),
        .min_pings    (min_pings_reg),
        .mem_ctl      (mem_ctl),
        .ping_raddr   (ping_raddr),
        .ping_waddr   (ping_waddr),
        .ping_wdata   (ping_wdata),
        .ping_rdata   (ping_rdata),
        .meta_addr    (meta_addr),
        .meta_wfill   (meta_wfill),
        .meta_wold    (meta_wold),
        .meta_rfill   (meta_rfill),
        .meta_rold    (meta_rold),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .stored_count (stored_count),
        .valid_count  (valid_count),
        .enough       (enough),
        .active_mask  (active_mask),
        .last_time    (last_time),
        .since_last   (since_last)
    );

    assign m_tdata = {7'd0, since_last, last_time, active_mask, enough,
                      valid_count, stored_count};

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import pswt_pkg::*;

    // Result fields, lowest bits last
    typedef struct packed {
        logic [31:0] since;
        logic [31:0] last;
        logic [15:0] mask;
        logic        enough;
        logic [3:0]  valid;
        logic [3:0]  stored;
    } report_t;

    typedef struct {
        logic [1:0]  op;
        logic [3:0]  src;
        logic [31:0] now;
        logic        pinned;
        report_t     report;
    } ping_row_t;

    localparam report_t NO_PINGS = '{since: '1, last: '0, mask: '0, enough: 1'b0,
                                     valid: '0, stored: '0};
    localparam report_t LONE_WRAPPED = '{since: 32'd1, last: 32'hFFFF_FFFF,
                                         mask: 16'h8000, enough: 1'b0,
                                         valid: 4'd1, stored: 4'd1};

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;    // source[3:0], now_ms[35:4]
    logic [S_TUSER_W-1:0]  s_tuser = '0;    // op[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // stored_count[3:0], valid_count[7:4], enough[8], active_mask[24:9],
    // last_time[56:25], since_last[88:57]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // pinned expectation travels alongside the item on the stream
    logic                  pin_en = 1'b0;
    report_t               pin_report = NO_PINGS;

    // predictor state
    logic [31:0] ring_time [16][8];
    logic [3:0]  ring_fill [16];
    logic [2:0]  ring_head [16];
    logic [15:0] model_timeout = TIMEOUT_RST;
    logic [3:0]  model_min = MIN_PINGS_RST;

    report_t     due_reports [$];
    int          mismatches = 0;
    int          tx_idle_pct = 21;
    int          rx_idle_pct = 61;
    logic [31:0] clock_ms = '0;
    ping_row_t   plan [$];

    per_source_ping_window_tracker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic is_fresh(logic [31:0] t, logic [31:0] now);
        logic [31:0] age;
        age = now - t;
        return age <= {16'd0, model_timeout};
    endfunction

    function automatic logic [3:0] fresh_count(int s, logic [31:0] now);
        logic [3:0] n;
        logic [2:0] slot;
        n = '0;
        for (int i = 0; i < ring_fill[s]; i++) begin
            slot = ring_head[s] + 3'(i);
            if (is_fresh(ring_time[s][slot], now))
                n++;
        end
        return n;
    endfunction

    // Apply one operation to the ping store and report on the addressed source
    function automatic report_t window_report(logic [1:0] op, logic [3:0] src,
                                              logic [31:0] now);
        report_t     rep;
        logic [31:0] kept_times [8];
        int          kept;
        logic [2:0]  slot;
        case (op)
            OP_ADD: begin
                if (ring_fill[src] < 4'd8) begin
                    slot = ring_head[src] + ring_fill[src][2:0];
                    ring_time[src][slot] = now;
                    ring_fill[src]++;
                end else begin
                    // full ring: overwrite the oldest and advance the head
                    ring_time[src][ring_head[src]] = now;
                    ring_head[src]++;
                end
            end
            OP_CLEANUP: begin
                for (int s = 0; s < 16; s++) begin
                    kept = 0;
                    for (int i = 0; i < ring_fill[s]; i++) begin
                        slot = ring_head[s] + 3'(i);
                        if (is_fresh(ring_time[s][slot], now)) begin
                            kept_times[kept] = ring_time[s][slot];
                            kept++;
                        end
                    end
                    // pack survivors from slot 0, order kept
                    for (int i = 0; i < kept; i++)
                        ring_time[s][i] = kept_times[i];
                    ring_fill[s] = 4'(kept);
                    ring_head[s] = '0;
                end
            end
            OP_CLEAR: begin
                for (int s = 0; s < 16; s++) begin
                    ring_fill[s] = '0;
                    ring_head[s] = '0;
                end
            end
            default: ;
        endcase

        rep = NO_PINGS;
        for (int s = 0; s < 16; s++)
            rep.mask[s] = (fresh_count(s, now) != 4'd0);
        rep.stored = ring_fill[src];
        rep.valid  = fresh_count(src, now);
        rep.enough = (rep.valid >= model_min);
        if (rep.stored != 4'd0) begin
            slot = ring_head[src] + 3'(rep.stored - 4'd1);
            rep.last  = ring_time[src][slot];
            rep.since = now - rep.last;
        end
        return rep;
    endfunction

    // Append one row to the stimulus table
    function automatic void queue_row(input logic [1:0] op, input logic [3:0] src,
                                      input logic [31:0] now, input logic pinned,
                                      input report_t report);
        ping_row_t row;
        row = '{op, src, now, pinned, report};
        plan.insert(plan.size(), row);
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        report_t want;
        report_t got;
        if (aresetn && s_tvalid && s_tready) begin
            want = window_report(s_tuser, s_tdata[3:0], s_tdata[35:4]);
            if (pin_en)
                want = pin_report;
            due_reports.insert(due_reports.size(), want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = report_t'(m_tdata[88:0]);
            if (due_reports.size() == 0) begin
                mismatches++;
                $display("%0t unexpected item: expected none actual %h", $time, got);
            end else begin
                want = due_reports.pop_front();
                if (got.stored !== want.stored) begin
                    mismatches++;
                    $display("%0t stored_count expected %0d actual %0d",
                             $time, want.stored, got.stored);
                end
                if (got.valid !== want.valid) begin
                    mismatches++;
                    $display("%0t valid_count expected %0d actual %0d",
                             $time, want.valid, got.valid);
                end
                if (got.enough !== want.enough) begin
                    mismatches++;
                    $display("%0t enough expected %b actual %b",
                             $time, want.enough, got.enough);
                end
                if (got.mask !== want.mask) begin
                    mismatches++;
                    $display("%0t active_mask expected %h actual %h",
                             $time, want.mask, got.mask);
                end
                if (got.last !== want.last) begin
                    mismatches++;
                    $display("%0t last_time expected %h actual %h",
                             $time, want.last, got.last);
                end
                if (got.since !== want.since) begin
                    mismatches++;
                    $display("%0t since_last expected %h actual %h",
                             $time, want.since, got.since);
                end
            end
        end
    end

    // Offer one item, holding tvalid high across back-to-back items
    task automatic send_item(input logic [1:0] op, input logic [3:0] src,
                             input logic [31:0] now, input logic pinned,
                             input report_t report);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= op;
        s_tdata    <= {4'd0, now, src};
        pin_en     <= pinned;
        pin_report <= report;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lower tvalid and wait for every outstanding report
    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_reports.size() != 0);
    endtask

    task automatic set_window(input logic [15:0] timeout, input logic [3:0] min_count);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_PINGS;
        cfg_wdata <= {12'd0, min_count};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        model_timeout = timeout;
        model_min     = min_count;
    endtask

    task automatic random_pings(input int count);
        logic [1:0] op;
        logic [3:0] src;
        int         pick;
        int         span;
        span = model_timeout / 64 + 1;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            op = (pick < 60) ? OP_ADD : (pick < 89) ? OP_QUERY :
                 (pick < 97) ? OP_CLEANUP : OP_CLEAR;
            // crowd a couple of sources so rings fill and wrap
            src = ($urandom_range(99) < 60) ? 4'($urandom_range(1)) : 4'($urandom_range(15));
            if ($urandom_range(99) < 3)
                clock_ms = $urandom;
            else
                clock_ms += 32'($urandom_range(0, span));
            send_item(op, src, clock_ms, 1'b0, NO_PINGS);
        end
    endtask

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        for (int s = 0; s < 16; s++) begin
            ring_fill[s] = '0;
            ring_head[s] = '0;
        end

        queue_row(OP_QUERY,   4'd0,  32'd0,          1'b1, NO_PINGS);
        queue_row(OP_ADD,     4'd0,  32'd100,        1'b0, NO_PINGS);
        queue_row(OP_ADD,     4'd0,  32'd200,        1'b0, NO_PINGS);
        queue_row(OP_ADD,     4'd0,  32'd300,        1'b0, NO_PINGS);
        // oldest ping exactly at the timeout, then one past it
        queue_row(OP_QUERY,   4'd0,  32'd1100,       1'b0, NO_PINGS);
        queue_row(OP_QUERY,   4'd0,  32'd1101,       1'b0, NO_PINGS);
        queue_row(OP_ADD,     4'd15, 32'hFFFF_FFFF,  1'b0, NO_PINGS);
        queue_row(OP_QUERY,   4'd15, 32'd0,          1'b1, LONE_WRAPPED);
        // nine pings into a ring of eight: the oldest is overwritten
        for (int i = 0; i < 9; i++)
            queue_row(OP_ADD, 4'd5, 32'(2000 + i),   1'b0, NO_PINGS);
        queue_row(OP_CLEANUP, 4'd5,  32'd3003,       1'b0, NO_PINGS);
        queue_row(OP_ADD,     4'd5,  32'd3004,       1'b0, NO_PINGS);
        queue_row(OP_QUERY,   4'd5,  32'd3004,       1'b0, NO_PINGS);
        queue_row(OP_CLEAR,   4'd0,  32'd3005,       1'b1, NO_PINGS);
        queue_row(OP_QUERY,   4'd5,  32'd4000,       1'b1, NO_PINGS);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i])
            send_item(plan[i].op, plan[i].src, plan[i].now, plan[i].pinned,
                      plan[i].report);
        drain();

        // zero timeout and zero threshold, time close to the wrap
        set_window(16'd0, 4'd0);
        clock_ms = 32'hFFFF_FF00;
        random_pings(126);
        drain();

        tx_idle_pct = 61;
        rx_idle_pct = 21;
        set_window(16'hFFFF, 4'd8);
        clock_ms = 32'hFFFF_0000;
        random_pings(126);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_window(16'($urandom_range(50, 3000)), 4'($urandom_range(1, 7)));
        clock_ms = $urandom;
        random_pings(126);
        drain();

        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: per_source_ping_window_tracker_top.f
rtl/core/pswt_pkg.sv
rtl/core/pswt_store.sv
rtl/core/pswt_ctrl.sv
rtl/core/per_source_ping_window_tracker_top.sv
bench/tb.sv
